@@ rtl/core/obst_pkg.sv @@
package obst_pkg;

  localparam int unsigned MAX_KEYS  = 16;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned COST_W    = 24;
  localparam int unsigned KCNT_W    = 5;
  localparam int unsigned IDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int unsigned TBL_AW    = 2 * IDX_W;
  localparam int unsigned TBL_DEPTH = 1 << TBL_AW;
  localparam int unsigned WSUM_W    = FREQ_W + CNT_W;
  localparam int unsigned LR_W      = COST_W + 1;
  localparam int unsigned TOT_W     = ((WSUM_W > LR_W) ? WSUM_W : LR_W) + 1;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             load_we;
    logic [IDX_W-1:0] load_idx;
    logic             rd_en;
    logic             clr;
    logic             wr_en;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] root;
  } dp_cmd_t;

  function automatic logic [KCNT_W-1:0] to_key_count(input logic [CNT_W-1:0] n);
    logic [CNT_W+KCNT_W-1:0] w;
    w = (CNT_W + KCNT_W)'(n);
    return w[KCNT_W-1:0];
  endfunction

endpackage

@@ rtl/core/obst_ctrl.sv @@
module obst_ctrl
  import obst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             last_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dp_cmd_t          cmd_o,
  output logic [CNT_W-1:0] key_count_o,
  output logic             too_many_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] root_q, root_d;
  logic             ovf_q, ovf_d;

  logic             in_acc;
  logic             room;
  logic [CNT_W:0]   hi_w;
  logic [CNT_W:0]   end_w;
  logic [IDX_W-1:0] hi;
  logic             more_lo;
  logic             more_len;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign room     = cnt_q < CNT_W'(MAX_KEYS);
  assign end_w    = (CNT_W + 1)'(lo_q) + (CNT_W + 1)'(len_q);
  assign hi_w     = end_w - (CNT_W + 1)'(1);
  assign hi       = hi_w[IDX_W-1:0];
  assign more_lo  = end_w < (CNT_W + 1)'(cnt_q);
  assign more_len = len_q < cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && last_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (root_q == hi) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_WRITE;
      ST_WRITE: begin
        if (more_lo || more_len) state_d = ST_RUN;
        else                     state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // interval walk: len outer, lo middle, root inner
  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    len_d  = len_q;
    lo_d   = lo_q;
    root_d = root_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (room) cnt_d = cnt_q + CNT_W'(1);
          else      ovf_d = 1'b1;
          if (last_i) begin
            len_d  = CNT_W'(1);
            lo_d   = '0;
            root_d = '0;
          end
        end
      end
      ST_RUN: begin
        if (root_q != hi) root_d = root_q + IDX_W'(1);
      end
      ST_DRAIN: ;
      ST_WRITE: begin
        if (more_lo) begin
          lo_d   = lo_q + IDX_W'(1);
          root_d = lo_q + IDX_W'(1);
        end else if (more_len) begin
          len_d  = len_q + CNT_W'(1);
          lo_d   = '0;
          root_d = '0;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_idx = cnt_q[IDX_W-1:0];
    cmd_o.lo       = lo_q;
    cmd_o.hi       = hi;
    cmd_o.root     = root_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_we = in_acc && room;
        cmd_o.clr     = in_acc && last_i;
      end
      ST_RUN:   cmd_o.rd_en = 1'b1;
      ST_DRAIN: ;
      ST_WRITE: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.clr   = 1'b1;
      end
      ST_OUT:   ;
      default:  ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign key_count_o = cnt_q;
  assign too_many_o  = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      len_q   <= '0;
      lo_q    <= '0;
      root_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      lo_q    <= lo_d;
      root_q  <= root_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_KEYS))
    else $error("key count above capacity");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (root_q >= lo_q) && (root_q <= hi) && (cnt_q != '0))
    else $error("root outside interval");

  a_out_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> (state_q == ST_IDLE) && (cnt_q == '0) && !ovf_q)
    else $error("set state not cleared after result beat");

endmodule

@@ rtl/core/obst_dp.sv @@
module obst_dp
  import obst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [FREQ_W-1:0] frequency_i,
  output logic [COST_W-1:0] min_cost_o
);

  logic [FREQ_W-1:0] freq_mem [MAX_KEYS];
  logic [COST_W-1:0] cost_mem [TBL_DEPTH];

  logic [IDX_W-1:0]  root_m1;
  logic [IDX_W-1:0]  root_p1;
  logic [COST_W-1:0] l_q, r_q;
  logic [FREQ_W-1:0] f_q;
  logic              use_l_q, use_r_q;
  logic              valid_q;
  logic [WSUM_W-1:0] weight_q;
  logic [LR_W-1:0]   min_q;
  logic [COST_W-1:0] result_q;
  logic [LR_W-1:0]   lr;
  logic [TOT_W-1:0]  total;
  logic [COST_W-1:0] total_sat;

  assign root_m1 = cmd_i.root - IDX_W'(1);
  assign root_p1 = cmd_i.root + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) freq_mem[cmd_i.load_idx] <= frequency_i;
    if (cmd_i.rd_en) begin
      f_q <= freq_mem[cmd_i.root];
      l_q <= cost_mem[{cmd_i.lo, root_m1}];
      r_q <= cost_mem[{root_p1, cmd_i.hi}];
      use_l_q <= (cmd_i.root != cmd_i.lo);
      use_r_q <= (cmd_i.root != cmd_i.hi);
    end
    if (cmd_i.wr_en) cost_mem[{cmd_i.lo, cmd_i.hi}] <= total_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= cmd_i.rd_en;
  end

  // empty side of the split costs nothing
  assign lr = (use_l_q ? LR_W'(l_q) : '0) + (use_r_q ? LR_W'(r_q) : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      weight_q <= '0;
      min_q    <= '1;
    end else if (valid_q) begin
      weight_q <= weight_q + WSUM_W'(f_q);
      if (lr < min_q) min_q <= lr;
    end
  end

  assign total     = TOT_W'(weight_q) + TOT_W'(min_q);
  assign total_sat = (total > TOT_W'(COST_MAX)) ? COST_MAX : total[COST_W-1:0];

  // last interval written is the full range
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) result_q <= total_sat;
  end

  assign min_cost_o = result_q;

  a_no_pending_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> !valid_q && !cmd_i.rd_en)
    else $error("interval written with a root still in flight");

endmodule

@@ rtl/core/optimal_bst_cost.sv @@
// Loading: one key beat per cycle, no stall while the block is idle.
// After the last beat the sequencer walks every interval of the n stored keys,
// one root per cycle through the cost table's two read ports, plus a drain
// and a write state per interval, before the result beat is valid.
// Input stalls from the last beat until the result beat is taken.
// Reset clears key count, overflow flag and sequencer; tables hold no reset value.
module optimal_bst_cost
  import obst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FREQ_W-1:0]   frequency_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [COST_W-1:0]   min_cost_o,
  output logic [KCNT_W-1:0]   key_count_o,
  output logic                too_many_o
);

  dp_cmd_t          cmd;
  logic [CNT_W-1:0] key_count;

  obst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .key_count_o (key_count),
    .too_many_o  (too_many_o)
  );

  obst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .frequency_i (frequency_i),
    .min_cost_o  (min_cost_o)
  );

  assign key_count_o = to_key_count(key_count);

endmodule
